[rtl/core/assert_macros.svh]
// Shared assertion macros for the rejection sampler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a implies b in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error(msg);

// Check that a implies b in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error(msg);

`endif

[rtl/core/brrw_pkg.sv]
`timescale 1ns / 1ps
package brrw_pkg;

    localparam int RANGE_W         = 31;
    localparam int DEF_WORD_WIDTH  = 32;

    // Partial remainders carried down the chain: one for the word, one for
    // the rejection threshold (2^W - range) mod range.
    typedef struct packed {
        logic [RANGE_W-1:0] rem_word;
        logic [RANGE_W-1:0] rem_thr;
    } t_cell_rem;

    // One restoring-division step: shift in a dividend bit, subtract the
    // divisor when it fits.
    function automatic logic [RANGE_W-1:0] rem_step(
        input logic [RANGE_W-1:0] rem,
        input logic               dbit,
        input logic [RANGE_W-1:0] divisor
    );
        logic [RANGE_W:0] shifted;
        logic [RANGE_W:0] diff;
        shifted = {rem, dbit};
        diff    = shifted - {1'b0, divisor};
        if (shifted >= {1'b0, divisor}) begin
            return diff[RANGE_W-1:0];
        end else begin
            return shifted[RANGE_W-1:0];
        end
    endfunction

endpackage

[rtl/core/brrw_word_if.sv]
`timescale 1ns / 1ps
interface brrw_word_if import brrw_pkg::*; #(
    parameter int WORD_WIDTH = DEF_WORD_WIDTH
) ();
    logic                  valid;
    logic                  ready;
    logic [WORD_WIDTH-1:0] random_word;

    modport source (output valid, output random_word, input ready);
    modport sink   (input valid, input random_word, output ready);
endinterface

[rtl/core/brrw_value_if.sv]
`timescale 1ns / 1ps
interface brrw_value_if import brrw_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [RANGE_W-1:0] bounded_value;

    modport source (output valid, output bounded_value, input ready);
    modport sink   (input valid, input bounded_value, output ready);
endinterface

[rtl/core/brrw_cell.sv]
`timescale 1ns / 1ps
module brrw_cell import brrw_pkg::*; #(
    parameter int WORD_WIDTH = DEF_WORD_WIDTH,
    parameter int BIT_IDX    = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_valid,
    input  logic [WORD_WIDTH-1:0] i_word,
    input  t_cell_rem             i_rem,
    input  logic [RANGE_W-1:0]    i_range,
    input  logic                  i_neg_bit,
    output logic                  o_valid,
    output logic [WORD_WIDTH-1:0] o_word,
    output t_cell_rem             o_rem
);

    logic                  r_valid;
    logic [WORD_WIDTH-1:0] r_word;
    t_cell_rem             r_rem;
    t_cell_rem             n_rem;

    always_comb begin
        n_rem.rem_word = rem_step(i_rem.rem_word, i_word[BIT_IDX], i_range);
        n_rem.rem_thr  = rem_step(i_rem.rem_thr, i_neg_bit, i_range);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_word <= i_word;
            r_rem  <= n_rem;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;
    assign o_rem   = r_rem;

endmodule

[rtl/core/brrw_emit.sv]
`timescale 1ns / 1ps
module brrw_emit import brrw_pkg::*; #(
    parameter int WORD_WIDTH = DEF_WORD_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_valid,
    input  logic [WORD_WIDTH-1:0] i_word,
    input  t_cell_rem             i_rem,
    input  logic [RANGE_W-1:0]    i_range,
    output logic                  o_valid,
    output logic [RANGE_W-1:0]    o_value
);

    localparam int CMP_W = (WORD_WIDTH > RANGE_W) ? WORD_WIDTH : RANGE_W;

    logic               r_valid;
    logic [RANGE_W-1:0] r_value;
    logic               w_keep;
    logic [RANGE_W-1:0] n_value;

    // Zero range passes every word and yields zero.
    always_comb begin
        w_keep  = (i_range == '0) ||
                  (CMP_W'(i_word) >= CMP_W'(i_rem.rem_thr));
        n_value = (i_range == '0) ? '0 : i_rem.rem_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid && w_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_value <= n_value;
        end
    end

    assign o_valid = r_valid;
    assign o_value = r_value;

endmodule

[rtl/core/bounded_random_rejection_word_top.sv]
// Channel   Dir  Payload                    Handshake
// i_word    in   random_word [WORD_WIDTH]   valid / ready
// o_value   out  bounded_value [31]         valid / ready
// cfg       in   i_cfg_wr_data [31]         i_cfg_wr_en, no wait
//
// One word per cycle while no result waits at the output; a word's result passes
// through the chain of one remainder cell per word bit and then the output
// register. Words below the threshold leave no result. Synchronous active-low
// reset empties the chain and clears range_size. The whole chain holds while
// a result waits at the output; i_word.ready is low only then.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bounded_random_rejection_word_top import brrw_pkg::*; #(
    parameter int WORD_WIDTH = DEF_WORD_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [RANGE_W-1:0] i_cfg_wr_data,
    brrw_word_if.sink          i_word,
    brrw_value_if.source       o_value
);

    logic [RANGE_W-1:0]    r_range_size;
    logic [RANGE_W-1:0]    n_range_size;
    logic [WORD_WIDTH-1:0] w_neg_range;
    logic                  w_adv;

    logic                  w_valid [0:WORD_WIDTH];
    logic [WORD_WIDTH-1:0] w_word  [0:WORD_WIDTH];
    t_cell_rem             w_rem   [0:WORD_WIDTH];

    always_comb begin
        n_range_size = i_cfg_wr_en ? i_cfg_wr_data : r_range_size;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_size <= '0;
        end else begin
            r_range_size <= n_range_size;
        end
    end

    // Threshold dividend: 2^W - range, taken mod 2^W.
    assign w_neg_range = WORD_WIDTH'(0) - WORD_WIDTH'(r_range_size);

    // Advance the chain unless the output holds an untaken word.
    assign w_adv        = !o_value.valid || o_value.ready;
    assign i_word.ready = w_adv;

    assign w_valid[0] = i_word.valid;
    assign w_word[0]  = i_word.random_word;
    assign w_rem[0]   = '0;

    for (genvar k = 0; k < WORD_WIDTH; k++) begin : g_cell
        brrw_cell #(
            .WORD_WIDTH (WORD_WIDTH),
            .BIT_IDX    (WORD_WIDTH - 1 - k)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_adv     (w_adv),
            .i_valid   (w_valid[k]),
            .i_word    (w_word[k]),
            .i_rem     (w_rem[k]),
            .i_range   (r_range_size),
            .i_neg_bit (w_neg_range[WORD_WIDTH - 1 - k]),
            .o_valid   (w_valid[k+1]),
            .o_word    (w_word[k+1]),
            .o_rem     (w_rem[k+1])
        );
    end

    brrw_emit #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_valid[WORD_WIDTH]),
        .i_word  (w_word[WORD_WIDTH]),
        .i_rem   (w_rem[WORD_WIDTH]),
        .i_range (r_range_size),
        .o_valid (o_value.valid),
        .o_value (o_value.bounded_value)
    );

    `ASSERT_IMPLIES(a_value_below_range, i_clk, i_rst_n,
        o_value.valid && (r_range_size != '0), o_value.bounded_value < r_range_size,
        "result not below range")
    `ASSERT_IMPLIES(a_zero_range_value, i_clk, i_rst_n,
        o_value.valid && (r_range_size == '0), o_value.bounded_value == '0,
        "nonzero result with zero range")
    `ASSERT_IMPLIES(a_ready_only_on_stall, i_clk, i_rst_n,
        !i_word.ready, o_value.valid && !o_value.ready,
        "input stalled without output backpressure")
    `ASSERT_NEXT(a_empty_chain_no_result, i_clk, i_rst_n,
        !w_valid[WORD_WIDTH] && w_adv, !o_value.valid,
        "result appeared from empty chain")

endmodule
